// ===== hw/rtl/lpbr_pkg.sv =====
package lpbr_pkg;

    localparam int TIME_W   = 14;
    localparam int POS_W    = 10;
    localparam int WIDTH_W  = 3;
    localparam int CHAN_W   = 8;
    localparam int COUNT_W  = 11;
    localparam int FRAC_W   = 16;
    localparam int ENV_W    = FRAC_W + 1;
    localparam int SCALE_W  = 2 * FRAC_W + 1;
    localparam int FACTOR_W = FRAC_W + 1;

    localparam logic [COUNT_W-1:0] PIXEL_COUNT_RESET = 11'd60;
    localparam logic [COUNT_W-1:0] PIXEL_COUNT_MAX   = 11'd1024;

    // side weights 0.9^(3^(i-1)) in q1.16, entry 0 is unity for the centre pixel
    function automatic logic [FACTOR_W-1:0] side_factor(input logic [WIDTH_W-1:0] k);
        logic [FACTOR_W-1:0] f;
        unique case (k)
            3'd0:    f = 17'd65536;
            3'd1:    f = 17'd58982;
            3'd2:    f = 17'd47775;
            3'd3:    f = 17'd25389;
            3'd4:    f = 17'd3810;
            3'd5:    f = 17'd12;
            default: f = 17'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== hw/rtl/lpbr_if.sv =====
interface lpbr_blob_if;
    logic                         valid;
    logic                         ready;
    logic [lpbr_pkg::TIME_W-1:0]  elapsed_ms;
    logic [lpbr_pkg::TIME_W-1:0]  life_ms;
    logic [lpbr_pkg::POS_W-1:0]   center_pos;
    logic [lpbr_pkg::WIDTH_W-1:0] side_width;
    logic [lpbr_pkg::CHAN_W-1:0]  red_in;
    logic [lpbr_pkg::CHAN_W-1:0]  green_in;
    logic [lpbr_pkg::CHAN_W-1:0]  blue_in;

    modport source (
        output valid, elapsed_ms, life_ms, center_pos, side_width, red_in, green_in, blue_in,
        input  ready
    );
    modport sink (
        input  valid, elapsed_ms, life_ms, center_pos, side_width, red_in, green_in, blue_in,
        output ready
    );
endinterface

interface lpbr_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [lpbr_pkg::POS_W-1:0]  pixel_index;
    logic [lpbr_pkg::CHAN_W-1:0] red_out;
    logic [lpbr_pkg::CHAN_W-1:0] green_out;
    logic [lpbr_pkg::CHAN_W-1:0] blue_out;
    logic                        last;

    modport source (
        output valid, pixel_index, red_out, green_out, blue_out, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_index, red_out, green_out, blue_out, last,
        output ready
    );
endinterface

interface lpbr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lpbr_pkg::COUNT_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// ===== hw/rtl/lpbr_divstep.sv =====
module lpbr_divstep (
    input  logic [lpbr_pkg::TIME_W-1:0] rem,
    input  logic                        bit_in,
    input  logic [lpbr_pkg::TIME_W-1:0] divisor,
    output logic [lpbr_pkg::TIME_W-1:0] rem_next,
    output logic                        q_bit
);

    logic [lpbr_pkg::TIME_W:0] trial;
    logic [lpbr_pkg::TIME_W:0] diff;

    // one restoring step: shift in a dividend bit, subtract when it fits
    assign trial = {rem, bit_in};
    assign diff  = trial - {1'b0, divisor};
    assign q_bit = (trial >= {1'b0, divisor});

    always_comb
    begin
        if (q_bit)
        begin
            rem_next = diff[lpbr_pkg::TIME_W-1:0];
        end
        else
        begin
            rem_next = trial[lpbr_pkg::TIME_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/led_pulse_blob_renderer.sv =====
// Pulsing blob renderer for an LED strip.
// blob: one transfer describes a blob at one moment (elapsed, lifetime, centre,
//   side width, peak colour). ready is high only while the sequencer is idle.
// pixel: one transfer per pixel write, centre first, then up to seven side
//   pixels below the centre wrapping round the strip; last marks the final one.
//   A blob whose elapsed time is not below its lifetime yields no transfer.
// cfg: writes pixel_count (strip length), always ready, reset value 60.
//   Write it only while the block is idle.
// Sequence: one shared restoring subtract step does the 16-step phase divide,
//   then 10 steps to reduce the centre modulo the strip length (skipped when
//   side width is 0), then a weight multiply and a colour scale for each pixel;
//   the sequencer holds while the pixel channel stalls.
// A finished pixel waits in the output register while the next one is formed;
// when the receiver stalls the sequencer holds until that register frees up.
// Reset (rst_n low, asynchronous) empties the output and returns to idle.
module led_pulse_blob_renderer (
    input  logic            clk,
    input  logic            rst_n,
    lpbr_blob_if.sink       blob,
    lpbr_pixel_if.source    pixel,
    lpbr_cfg_if.sink        cfg
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_PIX   = 3'd4;

    localparam int TW = lpbr_pkg::TIME_W;
    localparam int PW = lpbr_pkg::POS_W;
    localparam int WW = lpbr_pkg::WIDTH_W;
    localparam int CW = lpbr_pkg::CHAN_W;
    localparam int NW = lpbr_pkg::COUNT_W;
    localparam int FW = lpbr_pkg::FRAC_W;
    localparam int EW = lpbr_pkg::ENV_W;
    localparam int SW = lpbr_pkg::SCALE_W;
    localparam int XW = lpbr_pkg::FACTOR_W;
    localparam int PRW = SW + CW;

    logic [2:0]    state_reg, state_next;
    logic [3:0]    step_reg, step_next;
    logic [TW-1:0] rem_reg, rem_next;
    logic [FW-1:0] quot_reg, quot_next;
    logic [TW-1:0] life_reg, life_next;
    logic [PW-1:0] center_reg, center_next;
    logic [WW-1:0] width_reg, width_next;
    logic [CW-1:0] red_reg, red_next;
    logic [CW-1:0] green_reg, green_next;
    logic [CW-1:0] blue_reg, blue_next;
    logic [WW-1:0] k_reg, k_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [SW-1:0] scale_reg, scale_next;
    logic [NW-1:0] pcount_reg, pcount_next;

    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] out_index_reg, out_index_next;
    logic [CW-1:0] out_red_reg, out_red_next;
    logic [CW-1:0] out_green_reg, out_green_next;
    logic [CW-1:0] out_blue_reg, out_blue_next;
    logic          out_last_reg, out_last_next;

    logic [NW-1:0]   strip_len;
    logic [TW-1:0]   unit_rem;
    logic            unit_bit;
    logic [TW-1:0]   unit_div;
    logic [TW-1:0]   unit_rem_next;
    logic            unit_q;
    logic [EW-1:0]   env;
    logic [EW+XW-1:0] scale_prod;
    logic [PRW-1:0]  prod_red;
    logic [PRW-1:0]  prod_green;
    logic [PRW-1:0]  prod_blue;
    logic [PW-1:0]   idx_dec;
    logic [NW-1:0]   strip_len_m1;
    logic            out_free;

    always_comb
    begin
        priority if (pcount_reg == '0)
        begin
            strip_len = NW'(1);
        end
        else if (pcount_reg > lpbr_pkg::PIXEL_COUNT_MAX)
        begin
            strip_len = lpbr_pkg::PIXEL_COUNT_MAX;
        end
        else
        begin
            strip_len = pcount_reg;
        end
    end

    assign strip_len_m1 = strip_len - NW'(1);

    // shared subtract step: phase divide, then centre modulo strip length
    always_comb
    begin
        unit_rem = rem_reg;
        if (state_reg == ST_MOD)
        begin
            unit_bit = center_reg[step_reg];
            unit_div = TW'(strip_len);
        end
        else
        begin
            unit_bit = 1'b0;
            unit_div = life_reg;
        end
    end

    lpbr_divstep u_divstep (
        .rem      (unit_rem),
        .bit_in   (unit_bit),
        .divisor  (unit_div),
        .rem_next (unit_rem_next),
        .q_bit    (unit_q)
    );

    // triangle envelope from the phase
    always_comb
    begin
        if (quot_reg[FW-1] == 1'b0)
        begin
            env = {quot_reg, 1'b0};
        end
        else
        begin
            env = EW'((EW+1)'(1) << (FW + 1)) - {quot_reg, 1'b0};
        end
    end

    assign scale_prod = (EW+XW)'(env) * (EW+XW)'(lpbr_pkg::side_factor(k_reg));
    assign prod_red   = PRW'(red_reg) * PRW'(scale_reg);
    assign prod_green = PRW'(green_reg) * PRW'(scale_reg);
    assign prod_blue  = PRW'(blue_reg) * PRW'(scale_reg);

    assign idx_dec  = (idx_reg == '0) ? strip_len_m1[PW-1:0] : idx_reg - PW'(1);
    assign out_free = !out_valid_reg || pixel.ready;

    assign blob.ready        = (state_reg == ST_IDLE);
    assign cfg.ready         = 1'b1;
    assign pixel.valid       = out_valid_reg;
    assign pixel.pixel_index = out_index_reg;
    assign pixel.red_out     = out_red_reg;
    assign pixel.green_out   = out_green_reg;
    assign pixel.blue_out    = out_blue_reg;
    assign pixel.last        = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        life_next      = life_reg;
        center_next    = center_reg;
        width_next     = width_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        scale_next     = scale_reg;
        pcount_next    = pcount_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_red_next   = out_red_reg;
        out_green_next = out_green_reg;
        out_blue_next  = out_blue_reg;
        out_last_next  = out_last_reg;

        if (cfg.valid)
        begin
            pcount_next = cfg.data;
        end

        if (out_valid_reg && pixel.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // a dead blob is taken and dropped
                if (blob.valid && (blob.elapsed_ms < blob.life_ms))
                begin
                    rem_next    = blob.elapsed_ms;
                    life_next   = blob.life_ms;
                    center_next = blob.center_pos;
                    width_next  = blob.side_width;
                    red_next    = blob.red_in;
                    green_next  = blob.green_in;
                    blue_next   = blob.blue_in;
                    step_next   = 4'(FW - 1);
                    k_next      = '0;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = unit_rem_next;
                quot_next = {quot_reg[FW-2:0], unit_q};
                step_next = step_reg - 4'd1;
                if (step_reg == '0)
                begin
                    if (width_reg == '0)
                    begin
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        rem_next   = '0;
                        step_next  = 4'(PW - 1);
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                rem_next  = unit_rem_next;
                step_next = step_reg - 4'd1;
                if (step_reg == '0)
                begin
                    idx_next   = unit_rem_next[PW-1:0];
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                scale_next = scale_prod[SW-1:0];
                state_next = ST_PIX;
            end
            ST_PIX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_red_next   = prod_red[2*FW+CW-1:2*FW];
                    out_green_next = prod_green[2*FW+CW-1:2*FW];
                    out_blue_next  = prod_blue[2*FW+CW-1:2*FW];
                    out_last_next  = (k_reg == width_reg);
                    if (k_reg == '0)
                    begin
                        out_index_next = center_reg;
                    end
                    else
                    begin
                        out_index_next = idx_dec;
                        idx_next       = idx_dec;
                    end
                    if (k_reg == width_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + WW'(1);
                        state_next = ST_SCALE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            k_reg         <= '0;
            pcount_reg    <= lpbr_pkg::PIXEL_COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
            pcount_reg    <= pcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        life_reg      <= life_next;
        center_reg    <= center_next;
        width_reg     <= width_next;
        red_reg       <= red_next;
        green_reg     <= green_next;
        blue_reg      <= blue_next;
        idx_reg       <= idx_next;
        scale_reg     <= scale_next;
        out_index_reg <= out_index_next;
        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
        out_blue_reg  <= out_blue_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// ===== tb/led_pulse_blob_renderer_test.sv =====
`timescale 1ns / 100ps

typedef logic [lpbr_pkg::TIME_W-1:0]  ms_t;
typedef logic [lpbr_pkg::POS_W-1:0]   pos_t;
typedef logic [lpbr_pkg::WIDTH_W-1:0] side_t;
typedef logic [lpbr_pkg::CHAN_W-1:0]  chan_t;
typedef logic [lpbr_pkg::COUNT_W-1:0] count_t;

typedef struct packed {
    logic [lpbr_pkg::TIME_W-1:0]  elapsed_ms;
    logic [lpbr_pkg::TIME_W-1:0]  life_ms;
    logic [lpbr_pkg::POS_W-1:0]   center_pos;
    logic [lpbr_pkg::WIDTH_W-1:0] side_width;
    logic [lpbr_pkg::CHAN_W-1:0]  red_in;
    logic [lpbr_pkg::CHAN_W-1:0]  green_in;
    logic [lpbr_pkg::CHAN_W-1:0]  blue_in;
} blob_t;

typedef struct packed {
    logic [lpbr_pkg::POS_W-1:0]  pixel_index;
    logic [lpbr_pkg::CHAN_W-1:0] red_out;
    logic [lpbr_pkg::CHAN_W-1:0] green_out;
    logic [lpbr_pkg::CHAN_W-1:0] blue_out;
    logic                        last;
} pixel_t;

class blob_pixel_scoreboard;
    pixel_t                       expected_pixels[$];
    logic [lpbr_pkg::COUNT_W-1:0] pixel_count;
    int                           mismatches;

    function new();
        pixel_count = lpbr_pkg::PIXEL_COUNT_RESET;
        mismatches  = 0;
    endfunction

    function void set_pixel_count(input logic [lpbr_pkg::COUNT_W-1:0] value);
        pixel_count = value;
    endfunction

    // decay weights 0.9^(3^(i-1)) held in q0.24, brought down to q0.16
    function longint unsigned side_weight(input int i);
        longint unsigned w;
        case (i)
            1:       w = 64'd15099494;
            2:       w = 64'd12230590;
            3:       w = 64'd6499837;
            4:       w = 64'd975590;
            5:       w = 64'd3298;
            default: w = 64'd0;
        endcase
        return w >> (24 - lpbr_pkg::FRAC_W);
    endfunction

    function void note_blob(input blob_t b);
        longint unsigned strip;
        longint unsigned phase;
        longint unsigned env;
        longint unsigned scale;
        longint unsigned numer;
        pixel_t          px;
        int              n;
        // a blob past its lifetime draws nothing
        if (b.elapsed_ms >= b.life_ms)
            return;
        strip = pixel_count;
        if (strip < 1)
            strip = 1;
        if (strip > 1024)
            strip = 1024;
        numer = b.elapsed_ms;
        phase = (numer << lpbr_pkg::FRAC_W) / b.life_ms;
        if (phase < (64'd1 << (lpbr_pkg::FRAC_W - 1)))
            env = 2 * phase;
        else
            env = (64'd1 << (lpbr_pkg::FRAC_W + 1)) - 2 * phase;

        px.pixel_index = b.center_pos;
        px.red_out     = chan_t'((b.red_in * env) >> lpbr_pkg::FRAC_W);
        px.green_out   = chan_t'((b.green_in * env) >> lpbr_pkg::FRAC_W);
        px.blue_out    = chan_t'((b.blue_in * env) >> lpbr_pkg::FRAC_W);
        px.last        = (b.side_width == 0);
        expected_pixels.push_back(px);

        n = int'(b.side_width);
        for (int i = 1; i <= n; i++)
        begin
            scale          = env * side_weight(i);
            px.pixel_index = pos_t'((b.center_pos + strip - i) % strip);
            px.red_out     = chan_t'((b.red_in * scale) >> (2 * lpbr_pkg::FRAC_W));
            px.green_out   = chan_t'((b.green_in * scale) >> (2 * lpbr_pkg::FRAC_W));
            px.blue_out    = chan_t'((b.blue_in * scale) >> (2 * lpbr_pkg::FRAC_W));
            px.last        = (i == n);
            expected_pixels.push_back(px);
        end
    endfunction

    function void compare_field(input string field, input longint unsigned want,
                                input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    function void check_pixel(input pixel_t got);
        pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            $display("%0t: pixel transfer with nothing expected, actual index %0d rgb %0d %0d %0d",
                     $time, got.pixel_index, got.red_out, got.green_out, got.blue_out);
            mismatches++;
            return;
        end
        want = expected_pixels.pop_front();
        compare_field("pixel_index", want.pixel_index, got.pixel_index);
        compare_field("red_out", want.red_out, got.red_out);
        compare_field("green_out", want.green_out, got.green_out);
        compare_field("blue_out", want.blue_out, got.blue_out);
        compare_field("last", want.last, got.last);
    endfunction
endclass

module led_pulse_blob_renderer_test;

    logic clk = 1'b0;
    logic rst_n;

    lpbr_blob_if  blob_bus ();
    lpbr_pixel_if pix_bus ();
    lpbr_cfg_if   cfg_bus ();

    blob_pixel_scoreboard board;
    bit                   sender_idles;
    bit                   receiver_idles;

    led_pulse_blob_renderer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .blob  (blob_bus),
        .pixel (pix_bus),
        .cfg   (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic blob_t make_blob(input int e, input int l, input int c, input int w,
                                        input int r, input int g, input int b);
        blob_t x;
        x.elapsed_ms = ms_t'(e);
        x.life_ms    = ms_t'(l);
        x.center_pos = pos_t'(c);
        x.side_width = side_t'(w);
        x.red_in     = chan_t'(r);
        x.green_in   = chan_t'(g);
        x.blue_in    = chan_t'(b);
        return x;
    endfunction

    function automatic blob_t random_blob(input int strip);
        blob_t x;
        int    life;
        if ($urandom_range(0, 9) < 2)
            life = $urandom_range(0, 20);
        else
            life = $urandom_range(0, 16383);
        x.life_ms = ms_t'(life);
        if (life > 0 && $urandom_range(0, 99) < 85)
            x.elapsed_ms = ms_t'($urandom_range(0, life - 1));
        else
            x.elapsed_ms = ms_t'($urandom_range(life, 16383));
        if ($urandom_range(0, 9) < 7)
            x.center_pos = pos_t'($urandom_range(0, strip - 1));
        else
            x.center_pos = pos_t'($urandom_range(0, 1023));
        x.side_width = side_t'($urandom_range(0, 7));
        x.red_in     = chan_t'($urandom_range(0, 255));
        x.green_in   = chan_t'($urandom_range(0, 255));
        x.blue_in    = chan_t'($urandom_range(0, 255));
        return x;
    endfunction

    task automatic send_blob(input blob_t b);
        int gap;
        gap = pick_gap(sender_idles);
        if (gap > 0)
        begin
            blob_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        blob_bus.valid      <= 1'b1;
        blob_bus.elapsed_ms <= b.elapsed_ms;
        blob_bus.life_ms    <= b.life_ms;
        blob_bus.center_pos <= b.center_pos;
        blob_bus.side_width <= b.side_width;
        blob_bus.red_in     <= b.red_in;
        blob_bus.green_in   <= b.green_in;
        blob_bus.blue_in    <= b.blue_in;
        do
            @(posedge clk);
        while (!blob_bus.ready);
        board.note_blob(b);
    endtask

    task automatic write_pixel_count(input logic [lpbr_pkg::COUNT_W-1:0] value);
        blob_bus.valid <= 1'b0;
        while (board.expected_pixels.size() != 0)
            @(posedge clk);
        // let the block settle before the strip length changes
        repeat (50) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        board.set_pixel_count(value);
    endtask

    // pixel receiver with random back-pressure
    initial
    begin
        pixel_t got;
        int     stall_left;
        stall_left = 0;
        pix_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pix_bus.valid && pix_bus.ready)
            begin
                got.pixel_index = pix_bus.pixel_index;
                got.red_out     = pix_bus.red_out;
                got.green_out   = pix_bus.green_out;
                got.blue_out    = pix_bus.blue_out;
                got.last        = pix_bus.last;
                board.check_pixel(got);
            end
            if (stall_left > 0)
            begin
                pix_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pix_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap(receiver_idles);
            end
        end
    end

    initial
    begin
        logic [lpbr_pkg::COUNT_W-1:0] strip_plan [8];
        logic [lpbr_pkg::COUNT_W-1:0] setting;
        blob_t                        b;
        int                           strip;
        int                           sent;

        board          = new();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        strip_plan     = '{11'd1, 11'd0, 11'd1024, 11'd2047, 11'd8, 11'd1025, 11'd1023, 11'd60};

        rst_n               = 1'b0;
        blob_bus.valid      <= 1'b0;
        blob_bus.elapsed_ms <= '0;
        blob_bus.life_ms    <= '0;
        blob_bus.center_pos <= '0;
        blob_bus.side_width <= '0;
        blob_bus.red_in     <= '0;
        blob_bus.green_in   <= '0;
        blob_bus.blue_in    <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.data        <= '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed blobs on the reset strip length
        send_blob(make_blob(0, 1, 0, 7, 255, 255, 255));
        send_blob(make_blob(1, 2, 3, 7, 255, 255, 255));
        send_blob(make_blob(16382, 16383, 59, 7, 255, 255, 255));
        send_blob(make_blob(8191, 16383, 30, 5, 255, 128, 1));
        send_blob(make_blob(8192, 16383, 30, 6, 1, 2, 4));
        send_blob(make_blob(5, 5, 10, 3, 255, 255, 255));
        send_blob(make_blob(16383, 0, 10, 3, 255, 255, 255));
        send_blob(make_blob(0, 0, 0, 0, 0, 0, 0));
        send_blob(make_blob(16383, 16383, 1023, 7, 255, 255, 255));
        send_blob(make_blob(0, 16383, 0, 0, 0, 0, 0));
        send_blob(make_blob(1000, 3000, 1023, 7, 255, 0, 128));
        send_blob(make_blob(12000, 16383, 59, 1, 170, 85, 255));
        send_blob(make_blob(2, 3, 0, 2, 255, 255, 255));
        send_blob(make_blob(1, 3, 1, 4, 200, 100, 50));
        send_blob(make_blob(7, 10, 5, 5, 255, 255, 255));
        send_blob(make_blob(4095, 8190, 512, 7, 255, 255, 255));
        send_blob(make_blob(10922, 16383, 6, 6, 127, 254, 15));
        send_blob(make_blob(3, 4, 2, 3, 240, 15, 170));

        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph < 8)
                setting = strip_plan[ph];
            else
                setting = count_t'($urandom_range(0, 2047));
            write_pixel_count(setting);
            strip = int'(setting);
            if (strip < 1)
                strip = 1;
            if (strip > 1024)
                strip = 1024;
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < 44)
            begin
                b = random_blob(strip);
                send_blob(b);
                sent++;
            end
        end
        blob_bus.valid <= 1'b0;

        while (board.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (board.mismatches == 0 && board.expected_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
